// ===== rtl/core/group_scaled_int8_matvec_macros.svh =====
// Assertion macros shared by the matrix-vector multiply RTL.
`ifndef GROUP_SCALED_INT8_MATVEC_MACROS_SVH
`define GROUP_SCALED_INT8_MATVEC_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define GSMV_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define GSMV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GSMV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gsmv_pkg.sv =====
// Types, constants and codes shared by the matrix-vector multiply modules.
package gsmv_pkg;

  localparam int MAX_GROUP   = 256;
  localparam int MAX_ROW     = 4096;
  localparam int MAX_ROWS    = 65536;

  localparam int GROUP_LEN_W = 9;
  localparam int ROW_LEN_W   = 13;
  localparam int ROW_CNT_W   = 17;
  localparam int POS_GROUP_W = $clog2(MAX_GROUP);
  localparam int POS_ROW_W   = $clog2(MAX_ROW);
  localparam int ROW_IDX_W   = 16;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = ROW_CNT_W;

  localparam int PROD_W      = 24;
  localparam int GACC_W      = 32;
  localparam int SCALED_W    = 48;
  localparam int SUM_W       = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd2;

  localparam logic [GROUP_LEN_W-1:0] GROUP_LEN_RESET = GROUP_LEN_W'(32);
  localparam logic [ROW_LEN_W-1:0]   ROW_LEN_RESET   = ROW_LEN_W'(256);
  localparam logic [ROW_CNT_W-1:0]   ROW_CNT_RESET   = ROW_CNT_W'(256);

  typedef struct packed {
    logic signed [7:0]  weight;
    logic signed [15:0] activation;
    logic [15:0]        group_scale;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] row_sum;
    logic [ROW_IDX_W-1:0]    row_index;
    logic                    last_row;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_GACC,
    ST_SCALE,
    ST_RADD,
    ST_EMIT
  } gsmv_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic gacc;
    logic scale;
    logic radd;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic fold;
    logic row_end;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/gsmv_dp.sv =====
// Datapath: configuration, position counters, multipliers, accumulators and result register.
`include "group_scaled_int8_matvec_macros.svh"

module gsmv_dp import gsmv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  logic [GROUP_LEN_W-1:0] group_length;
  logic [ROW_LEN_W-1:0]   row_length;
  logic [ROW_CNT_W-1:0]   row_count;

  logic [GROUP_LEN_W-1:0] glen;
  logic [ROW_LEN_W-1:0]   rlen;
  logic [ROW_CNT_W-1:0]   rcnt;

  logic [POS_GROUP_W-1:0] pos_group;
  logic [POS_ROW_W-1:0]   pos_row;
  logic [ROW_IDX_W-1:0]   current_row;

  logic group_end;
  logic row_end;
  logic last;

  logic signed [7:0]  weight_q;
  logic signed [15:0] act_q;
  logic [15:0]        scale_q;
  logic               fold_q;
  logic               row_end_q;
  logic               last_q;
  logic [ROW_IDX_W-1:0] index_q;

  logic signed [PROD_W-1:0]   prod;
  logic signed [GACC_W-1:0]   gacc;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SUM_W-1:0]    racc;

  logic signed [GACC_W+16:0]  scale_full;
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    sum_sat;

  // Lengths of zero act as one; oversized lengths stick at the maximum.
  always_comb begin
    if (group_length == '0) begin
      glen = GROUP_LEN_W'(1);
    end else if (group_length > GROUP_LEN_W'(MAX_GROUP)) begin
      glen = GROUP_LEN_W'(MAX_GROUP);
    end else begin
      glen = group_length;
    end
    if (row_length == '0) begin
      rlen = ROW_LEN_W'(1);
    end else if (row_length > ROW_LEN_W'(MAX_ROW)) begin
      rlen = ROW_LEN_W'(MAX_ROW);
    end else begin
      rlen = row_length;
    end
    if (row_count == '0) begin
      rcnt = ROW_CNT_W'(1);
    end else if (row_count > ROW_CNT_W'(MAX_ROWS)) begin
      rcnt = ROW_CNT_W'(MAX_ROWS);
    end else begin
      rcnt = row_count;
    end
  end

  // A greater-or-equal test keeps working when a length shrinks mid-stream.
  assign group_end = (GROUP_LEN_W'(pos_group) + GROUP_LEN_W'(1)) >= glen;
  assign row_end   = (ROW_LEN_W'(pos_row) + ROW_LEN_W'(1)) >= rlen;
  assign last      = (ROW_CNT_W'(current_row) + ROW_CNT_W'(1)) >= rcnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_length <= GROUP_LEN_RESET;
      row_length   <= ROW_LEN_RESET;
      row_count    <= ROW_CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GROUP_LENGTH: group_length <= cfg_data[GROUP_LEN_W-1:0];
        CFG_ROW_LENGTH:   row_length   <= cfg_data[ROW_LEN_W-1:0];
        CFG_ROW_COUNT:    row_count    <= cfg_data[ROW_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Counters advance as the item is taken in; its flags are kept for the later steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_group   <= '0;
      pos_row     <= '0;
      current_row <= '0;
    end else if (cmd.load) begin
      if (group_end || (row_end && last)) begin
        pos_group <= '0;
      end else begin
        pos_group <= pos_group + POS_GROUP_W'(1);
      end
      if (row_end) begin
        pos_row <= '0;
        if (last) begin
          current_row <= '0;
        end else begin
          current_row <= current_row + ROW_IDX_W'(1);
        end
      end else begin
        pos_row <= pos_row + POS_ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      weight_q  <= in_item.weight;
      act_q     <= in_item.activation;
      scale_q   <= in_item.group_scale;
      fold_q    <= group_end || row_end;
      row_end_q <= row_end;
      last_q    <= last;
      index_q   <= current_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(weight_q) * PROD_W'(act_q);
    end
  end

  assign scale_full = gacc * $signed({1'b0, scale_q});

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      scaled <= scale_full[SCALED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gacc <= '0;
    end else if (cmd.gacc) begin
      gacc <= gacc + GACC_W'(prod);
    end else if (cmd.scale) begin
      gacc <= '0;
    end
  end

  // Saturate when the carry out disagrees with the sign of the 64-bit sum.
  assign sum_wide = {racc[SUM_W-1], racc} + (SUM_W+1)'(scaled);

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      racc <= '0;
    end else if (cmd.radd) begin
      racc <= sum_sat;
    end else if (cmd.emit) begin
      racc <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.row_sum   <= racc;
      out_item.row_index <= index_q;
      out_item.last_row  <= last_q;
    end
  end

  assign status.fold     = fold_q;
  assign status.row_end  = row_end_q;
  assign status.out_free = !out_valid || out_ready;

  `GSMV_ASSERT_NEXT(a_matrix_wrap, cmd.load && row_end && last, (pos_group == '0) && (pos_row == '0) && (current_row == '0), "counters did not restart after the last row")
  `GSMV_ASSERT_IMPL(a_result_source, $rose(out_valid), $past(cmd.emit), "result appeared without an emit step")
  `GSMV_ASSERT_IMPL(a_emit_slot_free, cmd.emit, status.out_free, "emit overwrote a result not yet transferred")

endmodule

// ===== rtl/core/gsmv_ctrl.sv =====
// Controller: sequences accept, multiply, accumulate, scale fold, row add and result emit for one item.
`include "group_scaled_int8_matvec_macros.svh"

module gsmv_ctrl import gsmv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  gsmv_state_t state;
  gsmv_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MUL;
      ST_MUL:   state_next = ST_GACC;
      ST_GACC:  state_next = status.fold ? ST_SCALE : ST_IDLE;
      ST_SCALE: state_next = ST_RADD;
      ST_RADD:  state_next = status.row_end ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:   cmd.mul   = 1'b1;
      ST_GACC:  cmd.gacc  = 1'b1;
      ST_SCALE: cmd.scale = 1'b1;
      ST_RADD:  cmd.radd  = 1'b1;
      ST_EMIT:  cmd.emit  = status.out_free;
      default: ;
    endcase
  end

  `GSMV_ASSERT_ALWAYS(a_one_command, $onehot0({cmd.load, cmd.mul, cmd.gacc, cmd.scale, cmd.radd, cmd.emit}), "more than one datapath command at once")
  `GSMV_ASSERT_NEXT(a_emit_waits, (state == ST_EMIT) && !status.out_free, state == ST_EMIT, "left emit before the result slot was free")
  `GSMV_ASSERT_IMPL(a_ready_only_idle, in_ready, state == ST_IDLE, "input taken while an item is in progress")

endmodule

// ===== rtl/core/group_scaled_int8_matvec.sv =====
// Top level of the group-scaled int8 matrix-vector multiply.
// Takes one weight per transfer with its activation (Q4.12) and group scale (Q0.16) and
// returns one saturated Q36.28 row sum per row. Items are processed one at a time by a
// controller stepping a shared datapath: an item inside a group goes through accept,
// weight times activation and group accumulate; an item that closes a group adds the
// group-by-scale multiply and saturating row add, and an item that closes a row adds the
// result emit, held while the previous row sum has not yet been transferred out. A finished
// row sum sits in an output register, so input keeps flowing while it waits. Configuration
// writes take effect on the next accepted item; position counters are kept across writes.
module group_scaled_int8_matvec import gsmv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  gsmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gsmv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the group-scaled int8 matrix-vector multiply.
module testbench;
  import gsmv_pkg::*;

  localparam int     RANDOM_ITEMS = 650;
  localparam int     LONG_ROW_ITEMS = 512;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     MAX_REPORTS = 10;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_STUTTER} rx_mode_t;

  // Tracks the row sums the block must produce, from its own copy of the state.
  class row_sum_board;
    logic [GROUP_LEN_W-1:0] group_len;
    logic [ROW_LEN_W-1:0]   row_len;
    logic [ROW_CNT_W-1:0]   row_cnt;
    longint                 group_acc;
    longint                 row_acc;
    int unsigned            pos_group;
    int unsigned            pos_row;
    int unsigned            row;
    out_item_t              rows_due[$];
    int                     mismatches;

    function new();
      group_len  = GROUP_LEN_RESET;
      row_len    = ROW_LEN_RESET;
      row_cnt    = ROW_CNT_RESET;
      group_acc  = 0;
      row_acc    = 0;
      pos_group  = 0;
      pos_row    = 0;
      row        = 0;
      mismatches = 0;
    endfunction

    // A length of zero counts as one; lengths above the hardware limit are clipped.
    function int unsigned eff_len(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GROUP_LENGTH: group_len = data[GROUP_LEN_W-1:0];
        CFG_ROW_LENGTH:   row_len = data[ROW_LEN_W-1:0];
        CFG_ROW_COUNT:    row_cnt = data[ROW_CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return rows_due.size();
    endfunction

    function void note_input(in_item_t it);
      int unsigned glen;
      int unsigned rlen;
      int unsigned rcnt;
      bit          group_end;
      bit          row_end;
      bit          last;
      longint      scaled;
      longint      sum;
      out_item_t   want;
      glen = eff_len(group_len, MAX_GROUP);
      rlen = eff_len(row_len, MAX_ROW);
      rcnt = eff_len(row_cnt, MAX_ROWS);
      group_end = (pos_group + 1 >= glen);
      row_end = (pos_row + 1 >= rlen);
      group_acc += longint'($signed(it.weight)) * longint'($signed(it.activation));
      if (group_end || row_end) begin
        // The scale that closes the segment applies to the whole segment.
        scaled = group_acc * longint'({48'd0, it.group_scale});
        sum = row_acc + scaled;
        if (row_acc[63] == scaled[63] && sum[63] != row_acc[63])
          sum = row_acc[63] ? SUM_MIN : SUM_MAX;
        row_acc = sum;
        group_acc = 0;
      end
      pos_group = group_end ? 0 : pos_group + 1;
      if (!row_end) begin
        pos_row++;
        return;
      end
      last = (row + 1 >= rcnt);
      want.row_sum = row_acc;
      want.row_index = row[ROW_IDX_W-1:0];
      want.last_row = last;
      rows_due.push_back(want);
      row_acc = 0;
      pos_row = 0;
      if (last) begin
        row = 0;
        pos_group = 0;
        group_acc = 0;
      end else begin
        row = (row + 1) & 32'hFFFF;
      end
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (rows_due.size() == 0) begin
        report($sformatf("row sum %0d for row %0d with none outstanding",
                         got.row_sum, got.row_index));
        return;
      end
      want = rows_due.pop_front();
      if (got.row_sum !== want.row_sum)
        report($sformatf("row %0d sum: expected %0d, got %0d",
                         want.row_index, want.row_sum, got.row_sum));
      if (got.row_index !== want.row_index)
        report($sformatf("row index: expected %0d, got %0d", want.row_index, got.row_index));
      if (got.last_row !== want.last_row)
        report($sformatf("row %0d last flag: expected %0b, got %0b",
                         want.row_index, want.last_row, got.last_row));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GROUP_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  row_sum_board book = new();
  int           burst_left = 0;
  logic [15:0]  held_scale = 16'hFFFF;
  rx_mode_t     rx_mode = RX_OPEN;
  int           rx_left = 0;
  int unsigned  rx_phase = 0;

  group_scaled_int8_matvec dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output side: check every transfer, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) book.check_result(out_item);
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (rx_phase % 8 == 0);
      default:   out_ready <= (rx_phase % 3 != 0);
    endcase
  end

  task automatic set_lengths(input logic [CFG_DATA_W-1:0] glen,
                             input logic [CFG_DATA_W-1:0] rlen,
                             input logic [CFG_DATA_W-1:0] rcnt);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GROUP_LENGTH;
    cfg_data <= glen;
    @(posedge clk);
    book.write_reg(CFG_GROUP_LENGTH, glen);
    cfg_index <= CFG_ROW_LENGTH;
    cfg_data <= rlen;
    @(posedge clk);
    book.write_reg(CFG_ROW_LENGTH, rlen);
    cfg_index <= CFG_ROW_COUNT;
    cfg_data <= rcnt;
    @(posedge clk);
    book.write_reg(CFG_ROW_COUNT, rcnt);
    cfg_we <= 1'b0;
  endtask

  // Valid stays up across a burst; most new bursts first drop it for a random gap.
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    book.note_input(it);
    burst_left--;
  endtask

  // Wait until every row sum is out and the last item has drained through.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The scale mostly holds for a while, as it would within a group.
  function automatic in_item_t rand_item(bit heavy);
    in_item_t it;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0:       held_scale = 16'h0000;
        1:       held_scale = 16'hFFFF;
        2:       held_scale = 16'h0001;
        default: held_scale = 16'($urandom);
      endcase
    end
    it.group_scale = held_scale;
    case ($urandom_range(0, 7))
      0:       it.weight = 8'sh80;
      1:       it.weight = 8'sh7F;
      default: it.weight = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       it.activation = 16'sh8000;
      1:       it.activation = 16'sh7FFF;
      default: it.activation = 16'($urandom);
    endcase
    if (heavy && $urandom_range(0, 3) != 0) begin
      it.weight = 8'sh80;
      it.activation = 16'sh8000;
      it.group_scale = 16'hFFFF;
    end
    return it;
  endfunction

  task automatic run_directed();
    in_item_t it;
    set_lengths(3, 5, 2);
    for (int i = 0; i < 20; i++) begin
      case (i % 5)
        0: it.weight = 8'sh80;
        1: it.weight = 8'sh7F;
        2: it.weight = 8'sh00;
        3: it.weight = 8'shFF;
        default: it.weight = 8'sh01;
      endcase
      case (i % 6)
        0: it.activation = 16'sh8000;
        1: it.activation = 16'sh7FFF;
        2: it.activation = 16'sh0000;
        3: it.activation = 16'shFFFF;
        4: it.activation = 16'sh0001;
        default: it.activation = 16'sh1000;
      endcase
      // Scales cycle with a period other than the group length, so groups mix them.
      case (i % 4)
        0: it.group_scale = 16'hFFFF;
        1: it.group_scale = 16'h0000;
        2: it.group_scale = 16'h8000;
        default: it.group_scale = 16'h0001;
      endcase
      send_item(it);
    end
    settle();
    // Zero lengths act as one: every item ends a group, a row and the matrix.
    set_lengths(0, 0, 0);
    for (int i = 0; i < 4; i++) begin
      it.weight = (i % 2 == 0) ? 8'sh7F : 8'sh80;
      it.activation = (i < 2) ? 16'sh7FFF : 16'sh8000;
      it.group_scale = (i == 3) ? 16'h0000 : 16'hFFFF;
      send_item(it);
    end
    settle();
  endtask

  // Long rows with an oversized group length, which is clipped to the largest group.
  task automatic run_full_row();
    set_lengths(17'h001FF, CFG_DATA_W'(LONG_ROW_ITEMS), 2);
    repeat (LONG_ROW_ITEMS) send_item(rand_item(1'b1));
    settle();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] glen;
    logic [CFG_DATA_W-1:0] rlen;
    logic [CFG_DATA_W-1:0] rcnt;
    int                    count;
    int                    sent;
    bit                    full_done;
    sent = 0;
    full_done = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       glen = 0;
        1:       glen = 1;
        2:       glen = CFG_DATA_W'(MAX_GROUP);
        3:       glen = CFG_DATA_W'($urandom_range(MAX_GROUP + 1, 511));
        default: glen = CFG_DATA_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 7))
        0:       rlen = 0;
        1:       rlen = 1;
        default: rlen = CFG_DATA_W'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 7))
        0:       rcnt = 0;
        1:       rcnt = 1;
        2:       rcnt = CFG_DATA_W'(MAX_ROWS);
        3:       rcnt = 17'h1FFFF;
        default: rcnt = CFG_DATA_W'($urandom_range(2, 6));
      endcase
      set_lengths(glen, rlen, rcnt);
      // Mostly whole rows; the rest stops mid-row so the next settings start mid-stream.
      if ($urandom_range(0, 9) < 7)
        count = $urandom_range(1, 8) * ((rlen == 0) ? 1 : int'(rlen));
      else
        count = $urandom_range(1, 60);
      repeat (count) send_item(rand_item(1'b0));
      sent += count;
      settle();
      if (!full_done && sent > RANDOM_ITEMS / 2) begin
        run_full_row();
        full_done = 1;
      end
    end
    settle();
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== group_scaled_int8_matvec.f =====
+incdir+rtl/core
rtl/core/gsmv_pkg.sv
rtl/core/gsmv_dp.sv
rtl/core/gsmv_ctrl.sv
rtl/core/group_scaled_int8_matvec.sv
test/testbench.sv
